FILE: rtl/core/fmrr_pkg.sv
package fmrr_pkg;

  localparam int FinCount = 4;
  localparam int FinIdxW  = $clog2(FinCount);

  localparam logic signed [26:0] ThrustGain = 27'sd500;
  localparam logic signed [26:0] ThrustBias = 27'sd24576000;
  localparam logic signed [26:0] ThrustMin  = 27'sd16384000;
  localparam logic signed [26:0] ThrustMax  = 27'sd32768000;
  localparam logic [10:0]        ThrustIdle = 11'd1500;
  localparam logic signed [15:0] DeadBand   = 16'sd819;

  localparam logic [15:0] XScaleMin = 16'd3277;
  localparam logic [15:0] XScaleMax = 16'd32768;

  localparam int CrossShift = 14;
  localparam int XShift     = 29;

  localparam logic [0:0]  MixLayoutRst = 1'b0;
  localparam logic [15:0] XScaleRst    = 16'd23170;
  localparam logic [3:0]  DirInvertRst = 4'd0;
  localparam logic [14:0] MaxAngleRst  = 15'd7680;
  localparam logic [14:0] ThresholdRst = 15'd128;
  localparam logic [15:0] HeartbeatRst = 16'd20;
  localparam logic [15:0] FinSpeedRst  = 16'd60;
  localparam logic [15:0] TicksRst     = 16'hFFFF;

  typedef enum logic [2:0] {
    RegMixLayout       = 3'd0,
    RegXScale          = 3'd1,
    RegDirInvert       = 3'd2,
    RegMaxAngle        = 3'd3,
    RegChangeThreshold = 3'd4,
    RegHeartbeatTicks  = 3'd5,
    RegFinSpeed        = 3'd6
  } cfg_reg_e;

  typedef enum logic [1:0] {
    CtlIdle,
    CtlScale,
    CtlMix,
    CtlDecide
  } ctl_state_e;

  typedef struct packed {
    logic               locked;
    logic signed [15:0] cmd_thrust;
    logic signed [15:0] cmd_pitch;
    logic signed [15:0] cmd_yaw;
  } in_t;

  typedef struct packed {
    logic [10:0]        thrust_pulse;
    logic               unlocked;
    logic               clear_integrators;
    logic signed [15:0] fin0_angle;
    logic signed [15:0] fin1_angle;
    logic signed [15:0] fin2_angle;
    logic signed [15:0] fin3_angle;
    logic               send_valid;
    logic [1:0]         send_index;
    logic signed [15:0] send_angle;
    logic [15:0]        send_speed;
  } out_t;

  typedef struct packed {
    logic               load;
    logic               scale;
    logic               mul_en;
    logic [FinIdxW-1:0] mul_idx;
    logic               clamp_en;
    logic [FinIdxW-1:0] clamp_idx;
    logic               decide;
  } cmd_t;

  typedef struct packed {
    logic out_full;
  } sts_t;

endpackage

FILE: rtl/core/fmrr_stream_if.sv
interface fmrr_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: rtl/core/fmrr_ctrl.sv
module fmrr_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  fmrr_pkg::sts_t    sts_i,
  output fmrr_pkg::cmd_t    cmd_o
);

  fmrr_pkg::ctl_state_e state_q, state_d;
  logic [2:0]           cnt_q, cnt_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= fmrr_pkg::CtlIdle;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    case (state_q)
      fmrr_pkg::CtlIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = fmrr_pkg::CtlScale;
        end
      end
      fmrr_pkg::CtlScale: begin
        cmd_o.scale = 1'b1;
        cnt_d       = '0;
        state_d     = fmrr_pkg::CtlMix;
      end
      fmrr_pkg::CtlMix: begin
        cmd_o.mul_en    = (cnt_q != 3'(fmrr_pkg::FinCount));
        cmd_o.mul_idx   = cnt_q[fmrr_pkg::FinIdxW-1:0];
        cmd_o.clamp_en  = (cnt_q != 3'd0);
        cmd_o.clamp_idx = cnt_q[fmrr_pkg::FinIdxW-1:0] - 2'd1;
        cnt_d           = cnt_q + 3'd1;
        if (cnt_q == 3'(fmrr_pkg::FinCount)) begin
          state_d = fmrr_pkg::CtlDecide;
        end
      end
      fmrr_pkg::CtlDecide: begin
        if (!sts_i.out_full) begin
          cmd_o.decide = 1'b1;
          state_d      = fmrr_pkg::CtlIdle;
        end
      end
      default: begin
        state_d = fmrr_pkg::CtlIdle;
      end
    endcase
  end

  a_busy_after_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |=> !in_ready_o)
    else $error("item accepted while previous item in flight");

endmodule

FILE: rtl/core/fmrr_dp.sv
module fmrr_dp (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cfg_we_i,
  input  logic [2:0]     cfg_idx_i,
  input  logic [15:0]    cfg_wdata_i,
  input  fmrr_pkg::in_t  in_data_i,
  input  fmrr_pkg::cmd_t cmd_i,
  output fmrr_pkg::sts_t sts_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output fmrr_pkg::out_t out_data_o
);

  localparam int IW = fmrr_pkg::FinIdxW;
  localparam int NF = fmrr_pkg::FinCount;

  logic        mix_q;
  logic [15:0] xscale_q;
  logic [3:0]  inv_q;
  logic [14:0] maxang_q;
  logic [14:0] thr_q;
  logic [15:0] hb_q;
  logic [15:0] speed_q;

  logic signed [15:0] pitch_q, yaw_q;
  logic [10:0]        thrust_q;
  logic               zero_q, clr_q, unlock_q;

  logic [30:0]        k_q;
  logic signed [49:0] prod_q;
  logic signed [15:0] fin_q [NF];

  logic [IW-1:0]      rr_q;
  logic signed [15:0] last_q  [NF];
  logic [15:0]        ticks_q [NF];

  logic           out_valid_q;
  fmrr_pkg::out_t out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mix_q    <= fmrr_pkg::MixLayoutRst;
      xscale_q <= fmrr_pkg::XScaleRst;
      inv_q    <= fmrr_pkg::DirInvertRst;
      maxang_q <= fmrr_pkg::MaxAngleRst;
      thr_q    <= fmrr_pkg::ThresholdRst;
      hb_q     <= fmrr_pkg::HeartbeatRst;
      speed_q  <= fmrr_pkg::FinSpeedRst;
    end else if (cfg_we_i) begin
      case (fmrr_pkg::cfg_reg_e'(cfg_idx_i))
        fmrr_pkg::RegMixLayout:       mix_q    <= cfg_wdata_i[0];
        fmrr_pkg::RegXScale:          xscale_q <= cfg_wdata_i;
        fmrr_pkg::RegDirInvert:       inv_q    <= cfg_wdata_i[3:0];
        fmrr_pkg::RegMaxAngle:        maxang_q <= cfg_wdata_i[14:0];
        fmrr_pkg::RegChangeThreshold: thr_q    <= cfg_wdata_i[14:0];
        fmrr_pkg::RegHeartbeatTicks:  hb_q     <= cfg_wdata_i;
        fmrr_pkg::RegFinSpeed:        speed_q  <= cfg_wdata_i;
        default: begin
        end
      endcase
    end
  end

  // thrust pulse and deadband
  logic signed [26:0] thr_lin, thr_clamp;
  logic               dead;

  always_comb begin
    thr_lin = 27'(in_data_i.cmd_thrust) * fmrr_pkg::ThrustGain + fmrr_pkg::ThrustBias;
    if (thr_lin < fmrr_pkg::ThrustMin) begin
      thr_clamp = fmrr_pkg::ThrustMin;
    end else if (thr_lin > fmrr_pkg::ThrustMax) begin
      thr_clamp = fmrr_pkg::ThrustMax;
    end else begin
      thr_clamp = thr_lin;
    end
    dead = (in_data_i.cmd_thrust >= -fmrr_pkg::DeadBand) &&
           (in_data_i.cmd_thrust <= fmrr_pkg::DeadBand);
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      pitch_q  <= in_data_i.cmd_pitch;
      yaw_q    <= in_data_i.cmd_yaw;
      unlock_q <= !in_data_i.locked;
      zero_q   <= in_data_i.locked || dead;
      clr_q    <= !in_data_i.locked && dead;
      thrust_q <= in_data_i.locked ? fmrr_pkg::ThrustIdle : thr_clamp[24:14];
    end
  end

  // shared multiplier
  function automatic logic signed [17:0] fin_sum(
    input logic               mix,
    input logic [IW-1:0]      idx,
    input logic signed [15:0] p,
    input logic signed [15:0] y,
    input logic               inv
  );
    logic signed [17:0] p18;
    logic signed [17:0] y18;
    logic signed [17:0] s;
    p18 = 18'(p);
    y18 = 18'(y);
    if (!mix) begin
      s = idx[1] ? y18 : p18;
    end else begin
      case (idx)
        2'd0:    s = p18 + y18;
        2'd1:    s = p18 - y18;
        2'd2:    s = y18 - p18;
        default: s = -p18 - y18;
      endcase
    end
    return inv ? -s : s;
  endfunction

  logic [15:0]        sc;
  logic signed [17:0] mul_a;
  logic signed [31:0] mul_b;
  logic signed [49:0] mul_p;

  always_comb begin
    if (xscale_q < fmrr_pkg::XScaleMin) begin
      sc = fmrr_pkg::XScaleMin;
    end else if (xscale_q > fmrr_pkg::XScaleMax) begin
      sc = fmrr_pkg::XScaleMax;
    end else begin
      sc = xscale_q;
    end
    if (cmd_i.scale) begin
      mul_a = $signed({2'b00, sc});
      mul_b = $signed({17'd0, maxang_q});
    end else begin
      mul_a = fin_sum(mix_q, cmd_i.mul_idx, pitch_q, yaw_q, inv_q[cmd_i.mul_idx]);
      mul_b = $signed({1'b0, k_q});
    end
    mul_p = 50'(mul_a) * 50'(mul_b);
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.scale) begin
      k_q <= mix_q ? mul_p[30:0] : {16'd0, maxang_q};
    end
    if (cmd_i.mul_en) begin
      prod_q <= mul_p;
    end
  end

  // shift and clamp
  logic signed [49:0] shifted, lim, clamped;

  always_comb begin
    shifted = mix_q ? (prod_q >>> fmrr_pkg::XShift) : (prod_q >>> fmrr_pkg::CrossShift);
    lim     = $signed({35'd0, maxang_q});
    if (shifted > lim) begin
      clamped = lim;
    end else if (shifted < -lim) begin
      clamped = -lim;
    end else begin
      clamped = shifted;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.clamp_en) begin
      fin_q[cmd_i.clamp_idx] <= zero_q ? 16'sd0 : clamped[15:0];
    end
  end

  // round-robin send decision
  logic [15:0]        tick_inc [NF];
  logic signed [15:0] target;
  logic signed [16:0] diff;
  logic [16:0]        delta;
  logic               send;

  always_comb begin
    for (int i = 0; i < NF; i++) begin
      tick_inc[i] = (ticks_q[i] == fmrr_pkg::TicksRst) ? ticks_q[i] : ticks_q[i] + 16'd1;
    end
    target = fin_q[rr_q];
    diff   = 17'(target) - 17'(last_q[rr_q]);
    delta  = diff[16] ? 17'(-diff) : 17'(diff);
    send   = (delta >= {2'b00, thr_q}) || (tick_inc[rr_q] >= hb_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rr_q        <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < NF; i++) begin
        last_q[i]  <= '0;
        ticks_q[i] <= fmrr_pkg::TicksRst;
      end
    end else if (cmd_i.decide) begin
      rr_q        <= rr_q + 2'd1;
      out_valid_q <= 1'b1;
      for (int i = 0; i < NF; i++) begin
        ticks_q[i] <= (send && (IW'(i) == rr_q)) ? 16'd0 : tick_inc[i];
      end
      if (send) begin
        last_q[rr_q] <= target;
      end
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.decide) begin
      out_q.thrust_pulse      <= thrust_q;
      out_q.unlocked          <= unlock_q;
      out_q.clear_integrators <= clr_q;
      out_q.fin0_angle        <= fin_q[0];
      out_q.fin1_angle        <= fin_q[1];
      out_q.fin2_angle        <= fin_q[2];
      out_q.fin3_angle        <= fin_q[3];
      out_q.send_valid        <= send;
      out_q.send_index        <= send ? rr_q : '0;
      out_q.send_angle        <= send ? target : 16'sd0;
      out_q.send_speed        <= send ? speed_q : 16'd0;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign out_data_o      = out_q;
  assign sts_o.out_full  = out_valid_q && !out_ready_i;

  a_decide_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.decide |=> out_valid_q)
    else $error("decision did not present an item");

  a_rr_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.decide |=> rr_q == $past(rr_q) + 2'd1)
    else $error("round-robin pointer did not advance");

  a_send_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.decide && send |=> ticks_q[$past(rr_q)] == 16'd0)
    else $error("heartbeat count not cleared on send");

endmodule

FILE: rtl/core/fin_mixer_round_robin_sender.sv
// Cross or X-tail fin mixer with a round-robin fin sender. Each accepted item is
// one control tick and yields exactly one result item: thrust pulse, lock and
// integrator-clear flags, the four clamped fin angles, and at most one fin send.
// An item passes the item register and thrust pulse, the X-layout scale product,
// the four fin products on the single shared 18x32 multiplier, their clamps, and
// the send decision, which waits while the output is full. A new item is taken
// once the last is decided. Configuration must be written through cfg_we_i,
// cfg_idx_i and cfg_wdata_i while no item is in flight; this is not enforced.
module fin_mixer_round_robin_sender (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_we_i,
  input  logic [2:0]    cfg_idx_i,
  input  logic [15:0]   cfg_wdata_i,
  fmrr_stream_if.sink   in_i,
  fmrr_stream_if.source out_o
);

  fmrr_pkg::cmd_t cmd;
  fmrr_pkg::sts_t sts;
  logic           in_ready;
  logic           out_valid;
  fmrr_pkg::out_t out_data;
  fmrr_pkg::in_t  in_data;

  assign in_data     = in_i.data;
  assign in_i.ready  = in_ready;
  assign out_o.valid = out_valid;
  assign out_o.data  = out_data;

  fmrr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  fmrr_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_data_i   (in_data),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_valid),
    .out_ready_i (out_o.ready),
    .out_data_o  (out_data)
  );

endmodule
